// ===== rtl/core/glba_pkg.sv =====
// shared types, widths and codes for the greedy line breaker and aligner
package glba_pkg;

	// default cap on the word counter of the open line
	localparam int unsigned MAX_LINE_WORDS_DEF = 255;

	// fixed field widths
	localparam int WORD_W    = 16;
	localparam int RUN_W     = 18;
	localparam int GAP_W     = 19;
	localparam int MAG_W     = 18;
	localparam int OUT_W     = 17;
	localparam int COUNT_W   = 8;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// running width saturates here
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	// alignment modes
	localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LEFT    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RIGHT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CENTER  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_JUSTIFY = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd2;

	// input transaction
	typedef struct packed {
		logic [WORD_W-1:0] word_width;
		logic              paragraph_end;
	} in_item_t;

	// output transaction, one per closed line
	typedef struct packed {
		logic signed [OUT_W-1:0] line_indent;
		logic [OUT_W-1:0]        line_spacing;
		logic [COUNT_W-1:0]      word_count;
		logic                    last_line;
	} out_line_t;

	// controller to datapath
	typedef struct packed {
		logic take_item;
		logic add_word;
		logic break_line;
		logic start_layout;
		logic layout_last;
		logic clear_line;
		logic div_start;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic brk;
		logic word_end;
		logic div_needed;
		logic div_busy;
		logic out_free;
		logic snap_last;
	} status_t;

endpackage

// ===== rtl/core/greedy_line_breaker_aligner_unit.sv =====
// Greedy line breaker and aligner: one word width per input transaction, one output
// transaction per closed line (two when a word both breaks the line and ends the
// paragraph). Items are handled one at a time by a state machine. A word that closes
// no line is accepted, then evaluated. A line closed by a break adds an output step
// (its layout shares the evaluate step); the paragraph's final line adds a layout
// step and an output step. In justify mode a broken line of two or more words also
// waits for the bit-serial divider that spreads the gap over the word gaps.
// Output waits in a register, so a stalled output delays only the item whose line is
// to be given next. Configuration is written through a plain write port with no
// read-back; writes to unused indexes are ignored.
module greedy_line_breaker_aligner_unit #(
	parameter int unsigned MAX_LINE_WORDS = glba_pkg::MAX_LINE_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [glba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [glba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  glba_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output glba_pkg::out_line_t            out_line
);
	import glba_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing
	glba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and storage
	glba_datapath #(
		.MAX_LINE_WORDS(MAX_LINE_WORDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_line  (out_line),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ===== rtl/core/glba_div.sv =====
// radix-2 restoring divider for the justify spacing, one quotient bit per cycle
module glba_div #(
	parameter int NW = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [glba_pkg::MAG_W-1:0] dividend,
	input  logic [NW-1:0]           divisor,
	output logic                    busy,
	output logic [glba_pkg::MAG_W-1:0] quotient
);
	import glba_pkg::*;

	localparam int CW = $clog2(MAG_W + 1);
	localparam logic [CW-1:0] STEPS = CW'(MAG_W);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [MAG_W-1:0] quo_q;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    div_q;
	logic [NW:0]      trial;

	// trial subtraction of the shifted remainder
	assign trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, div_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NW-2:0], quo_q[MAG_W-1]};
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/glba_datapath.sv =====
// datapath: configuration, open line state, layout arithmetic and output register
module glba_datapath #(
	parameter int unsigned MAX_LINE_WORDS = glba_pkg::MAX_LINE_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [glba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [glba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  glba_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output glba_pkg::out_line_t            out_line,
	input  glba_pkg::cmd_t                 cmd,
	output glba_pkg::status_t              status
);
	import glba_pkg::*;

	localparam int NW = $clog2(MAX_LINE_WORDS + 1);
	localparam int NX = (NW > COUNT_W) ? NW : COUNT_W;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_LINE_WORDS);
	localparam logic signed [GAP_W-1:0] IND_MAX = 19'sd65535;
	localparam logic signed [GAP_W-1:0] IND_MIN = -19'sd65535;
	localparam logic signed [GAP_W:0]   SPC_MAX = 20'sd131070;

	// configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [WORD_W-1:0] space_q;
	logic [WORD_W-1:0] lwidth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LEFT;
			space_q  <= 16'd64;
			lwidth_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ALIGN_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
				REG_SPACE_WIDTH: space_q  <= cfg_data;
				REG_LINE_WIDTH:  lwidth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// accepted transaction
	logic [WORD_W-1:0] word_q;
	logic              end_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			word_q <= in_item.word_width;
			end_q  <= in_item.paragraph_end;
		end
	end

	// open line state
	logic [RUN_W-1:0] run_q;
	logic [NW-1:0]    words_q;
	logic [GAP_W-1:0] sum_cur;
	logic [GAP_W-1:0] sum_base;
	logic [RUN_W-1:0] run_base;
	logic [NW-1:0]    n_base;
	logic [RUN_W-1:0] run_next;
	logic [NW-1:0]    n_next;
	logic             brk;

	assign sum_cur = GAP_W'(run_q) + GAP_W'(space_q) + GAP_W'(word_q);
	assign brk = (mode_q != MODE_NONE) && (words_q != '0) && (sum_cur > GAP_W'(lwidth_q));

	// a break clears the line before the word is added
	always_comb begin
		run_base = cmd.break_line ? '0 : run_q;
		n_base   = cmd.break_line ? '0 : words_q;
		sum_base = GAP_W'(run_base) + GAP_W'(space_q) + GAP_W'(word_q);
		if (n_base == '0) begin
			run_next = RUN_W'(word_q);
		end else if (sum_base > GAP_W'(RUN_MAX)) begin
			run_next = RUN_MAX;
		end else begin
			run_next = sum_base[RUN_W-1:0];
		end
		n_next = (n_base < MAX_N) ? n_base + 1'b1 : n_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			words_q <= '0;
		end else if (cmd.clear_line) begin
			run_q   <= '0;
			words_q <= '0;
		end else if (cmd.add_word) begin
			run_q   <= run_next;
			words_q <= n_next;
		end
	end

	// gap of the open line and its magnitude
	logic signed [GAP_W-1:0] gap_now;
	logic signed [GAP_W-1:0] gap_neg;
	logic [MAG_W-1:0]        gap_mag;

	assign gap_now = $signed(GAP_W'(lwidth_q)) - $signed(GAP_W'(run_q));
	assign gap_neg = -gap_now;
	assign gap_mag = gap_now[GAP_W-1] ? gap_neg[MAG_W-1:0] : gap_now[MAG_W-1:0];

	// line snapshot for layout
	logic signed [GAP_W-1:0] snap_gap_q;
	logic [NW-1:0]           snap_n_q;
	logic                    snap_last_q;

	always_ff @(posedge clk) begin
		if (cmd.start_layout) begin
			snap_gap_q  <= gap_now;
			snap_n_q    <= words_q;
			snap_last_q <= cmd.layout_last;
		end
	end

	// justify division of the gap over the word gaps
	logic             div_busy;
	logic [MAG_W-1:0] quo_mag;

	glba_div #(
		.NW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (gap_mag),
		.divisor  (words_q - 1'b1),
		.busy     (div_busy),
		.quotient (quo_mag)
	);

	// layout of the snapshot line
	logic [MODE_W-1:0]       mode_eff;
	logic signed [GAP_W-1:0] gap_adj;
	logic signed [GAP_W-1:0] gap_half;
	logic signed [GAP_W:0]   quo_pos;
	logic signed [GAP_W:0]   quo_sgn;
	logic signed [GAP_W:0]   space_ext;
	logic signed [GAP_W-1:0] indent_raw;
	logic signed [GAP_W:0]   spacing_raw;
	logic signed [GAP_W-1:0] indent_c;
	logic signed [GAP_W:0]   spacing_c;
	logic [NX-1:0]           n_ext;
	logic [COUNT_W-1:0]      count_c;

	always_comb begin
		mode_eff  = (mode_q > MODE_JUSTIFY) ? MODE_LEFT : mode_q;
		// halving towards zero
		gap_adj   = snap_gap_q + $signed({{(GAP_W-1){1'b0}}, snap_gap_q[GAP_W-1]});
		gap_half  = gap_adj >>> 1;
		quo_pos   = $signed({2'b00, quo_mag});
		quo_sgn   = snap_gap_q[GAP_W-1] ? -quo_pos : quo_pos;
		space_ext = $signed({4'b0000, space_q});

		indent_raw  = '0;
		spacing_raw = space_ext;
		case (mode_eff)
			MODE_RIGHT:  indent_raw = snap_gap_q;
			MODE_CENTER: indent_raw = gap_half;
			MODE_JUSTIFY: begin
				if (!snap_last_q) begin
					spacing_raw = (snap_n_q > NW'(1)) ? space_ext + quo_sgn : '0;
				end
			end
			default: ;
		endcase

		if (indent_raw > IND_MAX) begin
			indent_c = IND_MAX;
		end else if (indent_raw < IND_MIN) begin
			indent_c = IND_MIN;
		end else begin
			indent_c = indent_raw;
		end

		if (spacing_raw < 0) begin
			spacing_c = '0;
		end else if (spacing_raw > SPC_MAX) begin
			spacing_c = SPC_MAX;
		end else begin
			spacing_c = spacing_raw;
		end

		n_ext   = NX'(snap_n_q);
		count_c = (n_ext > NX'(255)) ? 8'hFF : n_ext[COUNT_W-1:0];
	end

	// output register
	logic      out_valid_q;
	out_line_t out_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_line_q.line_indent  <= indent_c[OUT_W-1:0];
			out_line_q.line_spacing <= spacing_c[OUT_W-1:0];
			out_line_q.word_count   <= count_c;
			out_line_q.last_line    <= snap_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_line  = out_line_q;

	// status back to the controller
	always_comb begin
		status.brk        = brk;
		status.word_end   = end_q;
		status.div_needed = (mode_q == MODE_JUSTIFY) && (words_q > NW'(1));
		status.div_busy   = div_busy;
		status.out_free   = !out_valid_q || !out_stall;
		status.snap_last  = snap_last_q;
	end

endmodule

// ===== rtl/core/glba_ctrl.sv =====
// controller: sequences word update, line layout, division and output
module glba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  glba_pkg::status_t  status,
	output glba_pkg::cmd_t     cmd
);
	import glba_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EVAL  = 5'b00010,
		ST_FINAL = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.add_word   = 1'b1;
				cmd.break_line = status.brk;
				if (status.brk) begin
					cmd.start_layout = 1'b1;
					cmd.div_start    = status.div_needed;
					state_d          = status.div_needed ? ST_DIV : ST_EMIT;
				end else if (status.word_end) begin
					state_d = ST_FINAL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			// the final line keeps the plain spacing in justify mode, so it never divides
			ST_FINAL: begin
				cmd.start_layout = 1'b1;
				cmd.layout_last  = 1'b1;
				cmd.clear_line   = 1'b1;
				state_d          = ST_EMIT;
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = (!status.snap_last && status.word_end) ? ST_FINAL : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/glba_checker.sv =====
// port-level checker for the line breaker, bound to the top level
module glba_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input glba_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_stall,
	input glba_pkg::out_line_t out_line
);
	import glba_pkg::*;

	// a stalled output transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	// a stalled output payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_line))
		else $error("output payload changed while stalled");

	// the block is busy in the cycle after it takes a word
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again straight after a transaction");

	// every closed line holds at least one word
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_line.word_count != '0)
		else $error("closed line with no words");

	// spacing stays within its clamp
	a_spacing_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_line.line_spacing <= 17'd131070)
		else $error("line spacing out of range");

endmodule

bind greedy_line_breaker_aligner_unit glba_checker u_glba_checker (.*);
